@@ sv/json_string_unescape_utf8_assert.svh @@
// Assertion helpers shared by the JSON string unescaper.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JSU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JSU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jsu_pkg.sv @@
// ============================================================================
// jsu_pkg
// Shared types and constants of the JSON string unescaper: decoder modes,
// status codes, the decoder state record and the result burst record.
// ============================================================================
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_BSL  = 3'd4,
        MODE_U    = 3'd5,
        MODE_LHEX = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        ST_BUSY       = 4'd0,
        ST_DONE       = 4'd1,
        ST_NO_QUOTE   = 4'd2,
        ST_CONTROL    = 4'd3,
        ST_UNFINISHED = 4'd4,
        ST_BAD_ESC    = 4'd5,
        ST_BAD_HEX    = 4'd6,
        ST_UNPAIRED   = 4'd7,
        ST_BAD_PAIR   = 4'd8,
        ST_UNTERM     = 4'd9
    } status_t;

    // Decoder state carried from one input transaction to the next.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] acc;
        logic [1:0]  cnt;
        logic [9:0]  hs;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        mode: MODE_WAIT,
        acc:  16'h0000,
        cnt:  2'd0,
        hs:   10'h000
    };

    // All results caused by one input transaction. bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_byte;
        status_t         status;
    } burst_t;

endpackage

`default_nettype wire

@@ sv/jsu_decode.sv @@
// ============================================================================
// jsu_decode
// Next-state and result logic for one raw byte of a JSON string literal,
// including the UTF-8 encoding of \uXXXX escapes and surrogate pairs.
// ============================================================================
`default_nettype none

module jsu_decode (
    input  jsu_pkg::dec_state_t state,
    input  logic [7:0]          in_byte,
    input  logic                text_end,
    output jsu_pkg::dec_state_t state_next,
    output jsu_pkg::burst_t     burst
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [5:0] HIGH_SUR_TOP = 6'b110110;
    localparam logic [5:0] LOW_SUR_TOP  = 6'b110111;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic burst_t one_byte(input logic [7:0] b);
        burst_t r;
        r          = '0;
        r.bytes[0] = b;
        r.has_byte = 1'b1;
        return r;
    endfunction

    // UTF-8 for a code point below 0x10000 (one to three bytes).
    function automatic burst_t enc_bmp(input logic [15:0] cp);
        burst_t r;
        r          = '0;
        r.has_byte = 1'b1;
        if (cp < 16'h0080)
        begin
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 16'h0800)
        begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end
        else
        begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end
        return r;
    endfunction

    // UTF-8 for a supplementary code point (always four bytes).
    function automatic burst_t enc_supp(input logic [20:0] cp);
        burst_t r;
        r          = '0;
        r.has_byte = 1'b1;
        r.bytes[0] = {5'b11110, cp[20:18]};
        r.bytes[1] = {2'b10, cp[17:12]};
        r.bytes[2] = {2'b10, cp[11:6]};
        r.bytes[3] = {2'b10, cp[5:0]};
        r.last_idx = 2'd3;
        return r;
    endfunction

    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic [20:0] cp_pair;
    status_t     st;
    burst_t      res;

    assign hex       = hex_digit(in_byte);
    assign acc_shift = {state.acc[11:0], hex[3:0]};
    assign cp_pair   = {1'b0, state.hs, acc_shift[9:0]} + 21'h010000;

    always_comb
    begin
        state_next = state;
        res        = '0;
        st         = ST_BUSY;
        unique case (state.mode)
            MODE_STR:
            begin
                priority if (text_end)
                begin
                    st = ST_UNTERM;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    st = ST_DONE;
                end
                else if (in_byte < CTRL_LIMIT)
                begin
                    st = ST_CONTROL;
                end
                else if (in_byte == CH_BSL)
                begin
                    state_next.mode = MODE_ESC;
                end
                else
                begin
                    res = one_byte(in_byte);
                end
            end
            MODE_ESC:
            begin
                if (text_end)
                begin
                    st = ST_UNFINISHED;
                end
                else
                begin
                    state_next.mode = MODE_STR;
                    unique case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: res = one_byte(in_byte);
                        CH_B: res = one_byte(8'h08);
                        CH_F: res = one_byte(8'h0C);
                        CH_N: res = one_byte(8'h0A);
                        CH_R: res = one_byte(8'h0D);
                        CH_T: res = one_byte(8'h09);
                        CH_U:
                        begin
                            state_next.mode = MODE_HEX;
                            state_next.acc  = 16'h0000;
                            state_next.cnt  = 2'd0;
                        end
                        default: st = ST_BAD_ESC;
                    endcase
                end
            end
            MODE_HEX, MODE_LHEX:
            begin
                if (text_end || !hex[4])
                begin
                    st = (state.mode == MODE_HEX) ? ST_BAD_HEX : ST_BAD_PAIR;
                end
                else if (state.cnt != 2'd3)
                begin
                    state_next.acc = acc_shift;
                    state_next.cnt = state.cnt + 2'd1;
                end
                else
                begin
                    state_next.acc = 16'h0000;
                    state_next.cnt = 2'd0;
                    if (state.mode == MODE_HEX)
                    begin
                        if (acc_shift[15:10] == HIGH_SUR_TOP)
                        begin
                            state_next.hs   = acc_shift[9:0];
                            state_next.mode = MODE_BSL;
                        end
                        else
                        begin
                            res             = enc_bmp(acc_shift);
                            state_next.mode = MODE_STR;
                        end
                    end
                    else if (acc_shift[15:10] != LOW_SUR_TOP)
                    begin
                        st = ST_BAD_PAIR;
                    end
                    else
                    begin
                        res             = enc_supp(cp_pair);
                        state_next.mode = MODE_STR;
                    end
                end
            end
            MODE_BSL:
            begin
                if (!text_end && in_byte == CH_BSL)
                begin
                    state_next.mode = MODE_U;
                end
                else
                begin
                    st = ST_UNPAIRED;
                end
            end
            MODE_U:
            begin
                if (!text_end && in_byte == CH_U)
                begin
                    state_next.mode = MODE_LHEX;
                    state_next.acc  = 16'h0000;
                    state_next.cnt  = 2'd0;
                end
                else
                begin
                    st = ST_UNPAIRED;
                end
            end
            default:
            begin
                if (!text_end && in_byte == CH_QUOTE)
                begin
                    state_next.mode = MODE_STR;
                end
                else
                begin
                    st = ST_NO_QUOTE;
                end
            end
        endcase

        // Any error or completion drops back to waiting for a quote.
        if (st != ST_BUSY)
        begin
            state_next = STATE_RESET;
        end
        res.status = st;
        burst      = res;
    end

endmodule

`default_nettype wire

@@ sv/json_string_unescape_utf8.sv @@
// ============================================================================
// json_string_unescape_utf8
// Streaming JSON string literal unescaper: takes raw text one byte per
// transaction and delivers the decoded string as UTF-8 bytes with a status.
// ============================================================================
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  -----------------------------------
//  text     text_valid / text_stall    in_byte, text_end
//  result   result_valid / result_stall out_byte, byte_valid, status, last
//
// Flow: every text transaction is decoded in the cycle it is accepted and
// becomes a burst of 1 to 4 result transactions. A \uXXXX escape takes one
// text transaction per input byte and yields its 1 to 4 result bytes on
// its final digit. The output port, one result per cycle while result_stall
// is low, sets the sustained rate.
// A two-entry burst queue sits between the decoder and the result port, so
// a new text transaction is taken while an earlier burst still waits.
// text_stall is high only while both queue entries are occupied; it comes
// straight from a register and has no path from result_stall.
// Reset (rst_n low, asynchronous) empties the queue and puts the decoder in
// the state of waiting for an opening quote. No clearing pass is needed.
//
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    // Raw text input.
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    // Decoded result output.
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [3:0] status,
    output logic       last
);
    import jsu_pkg::*;

    // Decoder state, advanced once per accepted text transaction.
    dec_state_t state_reg;
    dec_state_t state_next;
    burst_t     burst;

    // Two-entry queue of result bursts.
    burst_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    // Position of the byte being offered inside the head burst.
    logic [1:0] idx_reg;

    burst_t     head;
    logic       push;
    logic       pop_byte;
    logic       pop_burst;

    jsu_decode u_decode (
        .state      (state_reg),
        .in_byte    (in_byte),
        .text_end   (text_end),
        .state_next (state_next),
        .burst      (burst)
    );

    assign text_stall   = (fill_reg == 2'd2);
    assign push         = text_valid && !text_stall;

    assign head         = slot_reg[rd_ptr_reg];
    assign result_valid = (fill_reg != 2'd0);
    assign pop_byte     = result_valid && !result_stall;
    assign pop_burst    = pop_byte && (idx_reg == head.last_idx);

    // The status rides only on the final result of a burst.
    assign last         = (idx_reg == head.last_idx);
    assign out_byte     = head.bytes[idx_reg];
    assign byte_valid   = head.has_byte;
    assign status       = last ? head.status : ST_BUSY;

    always_comb
    begin
        unique case ({push, pop_burst})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                state_reg  <= state_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_burst)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                idx_reg    <= 2'd0;
            end
            else if (pop_byte)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Queue storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= burst;
        end
    end

    `JSU_ASSERT_IMP(a_idx_in_burst, result_valid, idx_reg <= head.last_idx,
        "byte index ran past the end of the head burst")
    `JSU_ASSERT_IMP(a_empty_burst_single, result_valid && !head.has_byte,
        head.last_idx == 2'd0, "burst without bytes must be a single result")
    `JSU_ASSERT_IMP(a_wait_is_clean, state_reg.mode == MODE_WAIT,
        state_reg.acc == 16'h0000 && state_reg.cnt == 2'd0 && state_reg.hs == 10'h000,
        "decoder waits for a quote with stale escape state")
    `JSU_ASSERT_NXT(a_push_shows, push && fill_reg == 2'd0, result_valid,
        "accepted transaction did not reach the result port")

endmodule

`default_nettype wire

@@ bench/tb_json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_json_string_unescape_utf8
// Self-checking bench for the streaming JSON string unescaper. A directed
// table covers the corners, then random string literals follow, most of them
// well formed and the rest broken in every way the decoder reports. The
// expected results come from a behavioral decoder kept inside the bench.
// ============================================================================

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam int RANDOM_ITEMS = 225;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 28;

    // One text transaction. When typed is set, the row carries its own
    // expected single result instead of relying on the decoder model.
    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       typed;
        logic [7:0] t_byte;
        logic       t_valid;
        status_t    t_status;
    } text_item_t;

    // One result transaction as it should leave the block.
    typedef struct {
        logic [7:0] data;
        logic       valid;
        status_t    st;
        logic       fin;
    } unesc_result_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       text_valid   = 1'b0;
    logic       text_stall;
    logic [7:0] in_byte      = 8'h00;
    logic       text_end     = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;

    json_string_unescape_utf8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .in_byte      (in_byte),
        .text_end     (text_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Shadow copy of the decoder state, advanced on every accepted text
    // transaction.
    dec_state_t    shadow_dec = STATE_RESET;
    logic [7:0]    burst_bytes[$];
    unesc_result_t decoded_q[$];
    text_item_t    sent_text_q[$];
    text_item_t    plan_q[$];
    int            errors      = 0;
    int            cycle_count = 0;
    int            sent_count  = 0;
    logic          calm        = 1'b0;

    // Directed table. Rows with an expectation typed in are the ones whose
    // result is obvious; the escape sequences in between go to the model.
    text_item_t directed_rows [29] = '{
        // Waiting for a quote: the smallest byte, then a bare text end.
        '{8'h00,    1'b0, 1'b1, 8'h00, 1'b0, ST_NO_QUOTE},
        '{8'hFF,    1'b1, 1'b1, 8'h00, 1'b0, ST_NO_QUOTE},
        // Open a string, pass the largest raw byte, then cut the text.
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{8'hFF,    1'b0, 1'b1, 8'hFF, 1'b1, ST_BUSY},
        '{8'h00,    1'b1, 1'b1, 8'h00, 1'b0, ST_UNTERM},
        // A control byte inside the string.
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{8'h1F,    1'b0, 1'b1, 8'h00, 1'b0, ST_CONTROL},
        // Simple escape, then the highest surrogate pair (U+10FFFF), close.
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{CH_BSL,   1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{CH_T,     1'b0, 1'b1, 8'h09, 1'b1, ST_BUSY},
        '{CH_BSL,   1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{CH_U,     1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h44,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h62,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h46,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h66,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{CH_BSL,   1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{CH_U,     1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h44,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h46,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h66,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{8'h46,    1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY},
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_DONE},
        // Text ends right after a backslash.
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{CH_BSL,   1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{8'h5A,    1'b1, 1'b1, 8'h00, 1'b0, ST_UNFINISHED},
        // Unknown escape letter.
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{CH_BSL,   1'b0, 1'b1, 8'h00, 1'b0, ST_BUSY},
        '{8'h78,    1'b0, 1'b1, 8'h00, 1'b0, ST_BAD_ESC}
    };

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    // Appends one decoded byte to the current burst.
    function automatic void append_out(input logic [7:0] b);
        burst_bytes.insert(burst_bytes.size(), b);
    endfunction

    // Code point to UTF-8, appended to the current burst.
    function automatic void encode_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            append_out(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            append_out({3'b110, cp[10:6]});
            append_out({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            append_out({4'b1110, cp[15:12]});
            append_out({2'b10, cp[11:6]});
            append_out({2'b10, cp[5:0]});
        end
        else
        begin
            append_out({5'b11110, cp[20:18]});
            append_out({2'b10, cp[17:12]});
            append_out({2'b10, cp[11:6]});
            append_out({2'b10, cp[5:0]});
        end
    endfunction

    // Decodes one text transaction against the shadow state. The decoded
    // bytes land in burst_bytes; the final status is returned.
    function automatic status_t unescape_byte(input logic [7:0] c, input logic eot);
        status_t     st;
        int          h;
        logic [20:0] cp;
        st = ST_BUSY;
        burst_bytes.delete();
        case (shadow_dec.mode)
            MODE_STR:
            begin
                if (eot) st = ST_UNTERM;
                else if (c == CH_QUOTE) st = ST_DONE;
                else if (c < 8'h20) st = ST_CONTROL;
                else if (c == CH_BSL) shadow_dec.mode = MODE_ESC;
                else append_out(c);
            end
            MODE_ESC:
            begin
                if (eot)
                begin
                    st = ST_UNFINISHED;
                end
                else
                begin
                    shadow_dec.mode = MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: append_out(c);
                        CH_B: append_out(8'h08);
                        CH_F: append_out(8'h0C);
                        CH_N: append_out(8'h0A);
                        CH_R: append_out(8'h0D);
                        CH_T: append_out(8'h09);
                        CH_U:
                        begin
                            shadow_dec.mode = MODE_HEX;
                            shadow_dec.acc  = 16'h0000;
                            shadow_dec.cnt  = 2'd0;
                        end
                        default: st = ST_BAD_ESC;
                    endcase
                end
            end
            MODE_HEX, MODE_LHEX:
            begin
                h = eot ? -1 : hex_value(c);
                if (h < 0)
                begin
                    if (shadow_dec.mode == MODE_HEX) st = ST_BAD_HEX;
                    else st = ST_BAD_PAIR;
                end
                else
                begin
                    shadow_dec.acc = {shadow_dec.acc[11:0], h[3:0]};
                    if (shadow_dec.cnt < 2'd3)
                    begin
                        shadow_dec.cnt = shadow_dec.cnt + 2'd1;
                    end
                    else
                    begin
                        shadow_dec.cnt = 2'd0;
                        if (shadow_dec.mode == MODE_HEX)
                        begin
                            // A high surrogate waits for its low half.
                            if (shadow_dec.acc >= 16'hD800 && shadow_dec.acc <= 16'hDBFF)
                            begin
                                shadow_dec.hs   = 10'(shadow_dec.acc - 16'hD800);
                                shadow_dec.mode = MODE_BSL;
                            end
                            else
                            begin
                                encode_utf8(21'(shadow_dec.acc));
                                shadow_dec.mode = MODE_STR;
                            end
                        end
                        else if (shadow_dec.acc < 16'hDC00 || shadow_dec.acc > 16'hDFFF)
                        begin
                            st = ST_BAD_PAIR;
                        end
                        else
                        begin
                            cp = 21'h10000 + (21'(shadow_dec.hs) << 10)
                                 + 21'(shadow_dec.acc - 16'hDC00);
                            encode_utf8(cp);
                            shadow_dec.mode = MODE_STR;
                        end
                        shadow_dec.acc = 16'h0000;
                    end
                end
            end
            MODE_BSL:
            begin
                if (!eot && c == CH_BSL) shadow_dec.mode = MODE_U;
                else st = ST_UNPAIRED;
            end
            MODE_U:
            begin
                if (!eot && c == CH_U)
                begin
                    shadow_dec.mode = MODE_LHEX;
                    shadow_dec.acc  = 16'h0000;
                    shadow_dec.cnt  = 2'd0;
                end
                else
                begin
                    st = ST_UNPAIRED;
                end
            end
            default:
            begin
                if (!eot && c == CH_QUOTE) shadow_dec.mode = MODE_STR;
                else st = ST_NO_QUOTE;
            end
        endcase
        // Every error and every completion drops back to waiting.
        if (st != ST_BUSY) shadow_dec = STATE_RESET;
        return st;
    endfunction

    // Turns an accepted text transaction into its expected results. The
    // model always runs so its state stays in step with the block, even
    // when a directed row supplies the expectation itself.
    function automatic void expect_text(input logic [7:0] c, input logic eot);
        text_item_t    meta;
        status_t       st;
        unesc_result_t r;
        st = unescape_byte(c, eot);
        if (sent_text_q.size() == 0)
        begin
            $error("text transaction accepted with nothing sent");
            errors++;
            return;
        end
        meta = sent_text_q.pop_front();
        if (meta.typed)
        begin
            r = '{meta.t_byte, meta.t_valid, meta.t_status, 1'b1};
            decoded_q.insert(decoded_q.size(), r);
        end
        else if (burst_bytes.size() == 0)
        begin
            r = '{8'h00, 1'b0, st, 1'b1};
            decoded_q.insert(decoded_q.size(), r);
        end
        else
        begin
            foreach (burst_bytes[k])
            begin
                if (k == burst_bytes.size() - 1) r = '{burst_bytes[k], 1'b1, st, 1'b1};
                else r = '{burst_bytes[k], 1'b1, ST_BUSY, 1'b0};
                decoded_q.insert(decoded_q.size(), r);
            end
        end
    endfunction

    function automatic void check_result();
        unesc_result_t exp;
        if (decoded_q.size() == 0)
        begin
            $error("result transaction with no expectation: out_byte=%0h status=%0d",
                   out_byte, status);
            errors++;
            return;
        end
        exp = decoded_q.pop_front();
        if (out_byte !== exp.data)
        begin
            $error("out_byte: expected %0h, actual %0h", exp.data, out_byte);
            errors++;
        end
        if (byte_valid !== exp.valid)
        begin
            $error("byte_valid: expected %0d, actual %0d", exp.valid, byte_valid);
            errors++;
        end
        if (status !== exp.st)
        begin
            $error("status: expected %0d, actual %0d", exp.st, status);
            errors++;
        end
        if (last !== exp.fin)
        begin
            $error("last: expected %0d, actual %0d", exp.fin, last);
            errors++;
        end
    endfunction

    // Both handshakes are observed at the rising edge with the values that
    // held just before it. Results are checked before the new text
    // transaction is predicted, since a burst never leaves in the cycle its
    // text is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall) check_result();
            if (text_valid && !text_stall) expect_text(in_byte, text_end);
        end
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one text transaction and returns at the edge that takes it.
    // Idle gaps are inserted before valid goes up, never while it is held.
    task automatic send_text(input text_item_t it);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        sent_text_q.insert(sent_text_q.size(), it);
        text_valid <= 1'b1;
        in_byte    <= it.data;
        text_end   <= it.eot;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        sent_count++;
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic drain_results();
        text_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
    endtask

    function automatic void add_byte(input logic [7:0] c);
        text_item_t it;
        it = '{c, 1'b0, 1'b0, 8'h00, 1'b0, ST_BUSY};
        plan_q.insert(plan_q.size(), it);
    endfunction

    // Text end; the byte that rides along is random since it is ignored.
    function automatic void add_end();
        text_item_t it;
        it = '{8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'h00, 1'b0, ST_BUSY};
        plan_q.insert(plan_q.size(), it);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_hex4(input logic [15:0] v);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function automatic void add_partial_hex();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) add_byte(hex_char(4'($urandom_range(0, 15))));
    endfunction

    // Either a byte that is no hex digit, or the end of the text.
    function automatic void add_bad_hex();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0)
        begin
            add_end();
        end
        else
        begin
            do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
            add_byte(c);
        end
    endfunction

    // Either a byte other than the one required, or the end of the text.
    function automatic void add_wrong(input logic [7:0] needed);
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0)
        begin
            add_end();
        end
        else
        begin
            do c = 8'($urandom_range(0, 255)); while (c == needed);
            add_byte(c);
        end
    endfunction

    function automatic void add_high_escape();
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
    endfunction

    // Builds one string literal: optional junk before the quote, a handful
    // of segments, then usually a clean close and otherwise an error.
    function automatic void build_literal();
        logic [7:0]  c;
        logic [15:0] v;
        int          nseg;
        if ($urandom_range(0, 3) == 0)
        begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
            begin
                if ($urandom_range(0, 3) == 0) add_end();
                else add_wrong(CH_QUOTE);
            end
        end
        add_byte(CH_QUOTE);
        nseg = $urandom_range(0, 6);
        for (int s = 0; s < nseg; s++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    do c = 8'($urandom_range(8'h20, 8'h7F));
                    while (c == CH_QUOTE || c == CH_BSL);
                    add_byte(c);
                end
                3: add_byte(8'($urandom_range(8'h80, 8'hFF)));
                4, 5:
                begin
                    add_byte(CH_BSL);
                    case ($urandom_range(0, 7))
                        0: add_byte(CH_QUOTE);
                        1: add_byte(CH_BSL);
                        2: add_byte(CH_SLASH);
                        3: add_byte(CH_B);
                        4: add_byte(CH_F);
                        5: add_byte(CH_N);
                        6: add_byte(CH_R);
                        default: add_byte(CH_T);
                    endcase
                end
                6, 7:
                begin
                    // One escape outside the high surrogates: one, two or
                    // three UTF-8 bytes, lone low surrogates included.
                    case ($urandom_range(0, 3))
                        0: v = 16'($urandom_range(0, 16'h007F));
                        1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
                        default: v = 16'($urandom_range(16'hDC00, 16'hFFFF));
                    endcase
                    add_byte(CH_BSL);
                    add_byte(CH_U);
                    add_hex4(v);
                end
                default:
                begin
                    add_high_escape();
                    add_byte(CH_BSL);
                    add_byte(CH_U);
                    add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            add_byte(CH_QUOTE);
        end
        else
        begin
            case ($urandom_range(0, 8))
                0: add_byte(8'($urandom_range(0, 8'h1F)));
                1: add_end();
                2:
                begin
                    add_byte(CH_BSL);
                    do c = 8'($urandom_range(0, 255));
                    while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N,
                                     CH_R, CH_T, CH_U});
                    add_byte(c);
                end
                3:
                begin
                    add_byte(CH_BSL);
                    add_end();
                end
                4:
                begin
                    add_byte(CH_BSL);
                    add_byte(CH_U);
                    add_partial_hex();
                    add_bad_hex();
                end
                5:
                begin
                    add_high_escape();
                    add_wrong(CH_BSL);
                end
                6:
                begin
                    add_high_escape();
                    add_byte(CH_BSL);
                    add_wrong(CH_U);
                end
                7:
                begin
                    add_high_escape();
                    add_byte(CH_BSL);
                    add_byte(CH_U);
                    add_partial_hex();
                    add_bad_hex();
                end
                default:
                begin
                    // Complete low escape that is not a low surrogate.
                    v = 16'($urandom_range(0, 16'hFFFF));
                    if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h4000;
                    add_high_escape();
                    add_byte(CH_BSL);
                    add_byte(CH_U);
                    add_hex4(v);
                end
            endcase
        end
    endfunction

    initial
    begin
        bit paused_once;
        paused_once = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) send_text(directed_rows[i]);
        // Let the directed part settle completely before random traffic.
        drain_results();

        while (sent_count < $size(directed_rows) + RANDOM_ITEMS)
        begin
            // A window with no idling on either side.
            calm = (sent_count >= 140 && sent_count < 200);
            if (!paused_once && sent_count >= 170)
            begin
                drain_results();
                paused_once = 1'b1;
            end
            build_literal();
            foreach (plan_q[i]) send_text(plan_q[i]);
            plan_q.delete();
        end
        calm = 1'b0;

        drain_results();
        // Keep the clock running to catch any stray result transaction.
        repeat (20) @(posedge clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
